FILE: hw/rtl/bpa_pkg.sv
// bpa_pkg: shared widths, register indexes and the adder result type
// for the bin packing assigner. No dependencies.
`default_nettype none

package bpa_pkg;

	localparam int SizeW   = 48;  // item size, bin capacity and bin fill
	localparam int SlotW   = 6;   // item slot field of a result
	localparam int BinW    = 6;   // bin index field of a result
	localparam int CfgIdxW = 2;   // register index on the config port

	localparam logic [CfgIdxW-1:0] CFG_BIN_CAPACITY = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_COMPACT_MODE = 2'd1;

	typedef struct packed {
		logic             fits;  // fill + size <= capacity
		logic [SizeW-1:0] sum;   // new fill, valid when fits
	} alu_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bpa_if.sv
// bpa_in_if / bpa_out_if: valid/ready channels of the bin packing assigner.
// Depends on bpa_pkg for field widths.
`default_nettype none

interface bpa_in_if;
	logic                      valid;
	logic                      ready;
	logic [bpa_pkg::SizeW-1:0] item_size;
	logic                      last_item;

	modport source (output valid, item_size, last_item, input ready);
	modport sink   (input valid, item_size, last_item, output ready);
endinterface

interface bpa_out_if;
	logic                      valid;
	logic                      ready;
	logic [bpa_pkg::SlotW-1:0] item_slot;
	logic [bpa_pkg::BinW-1:0]  bin_index;
	logic                      too_large;
	logic                      last_result;

	modport source (output valid, item_slot, bin_index, too_large, last_result,
		input ready);
	modport sink   (input valid, item_slot, bin_index, too_large, last_result,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bpa_alu.sv
// bpa_alu: shared fill adder and capacity compare, used for the oversize
// check and for every packing step. Depends on bpa_pkg.
`default_nettype none

module bpa_alu (
	input  wire logic [bpa_pkg::SizeW-1:0] fill,
	input  wire logic [bpa_pkg::SizeW-1:0] size,
	input  wire logic [bpa_pkg::SizeW-1:0] capacity,
	output bpa_pkg::alu_res_t              res
);

	logic [bpa_pkg::SizeW:0] sum;

	// one extra bit: the sum of two SizeW values cannot overflow
	assign sum      = {1'b0, fill} + {1'b0, size};
	assign res.fits = (sum <= {1'b0, capacity});
	assign res.sum  = sum[bpa_pkg::SizeW-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/bin_packing_assigner.sv
// bin_packing_assigner: loads a set of item sizes, packs them next-fit or first-fit
// per bin, emits one bin index per item in load order, or one too_large result.
// Depends on bpa_pkg, bpa_if (bpa_in_if, bpa_out_if) and bpa_alu.
//
//   channel   dir   transaction                            when taken
//   items     in    item_size, last_item                   valid & ready
//   results   out   item_slot, bin_index, too_large,       valid & ready
//                   last_result
//   cfg       in    cfg_index, cfg_data                    cfg_we high
//
// Loading never stalls an item: ready is high throughout loading and only then.
// After the marked last item: an oversize check reads and compares each stored
// size, then packing passes scan the items (an unassigned item is read and tried,
// an assigned one skipped), then each result is read back from the bin store.
// Check and packing run through the one size memory read port and the one shared adder.
// Reset clears the sequencer, counters, assigned flags and registers; the
// memories are not cleared, only written entries are read.
// A stalled result holds in the output register; the sequencer waits on it.
`default_nettype none

module bin_packing_assigner #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bpa_in_if.sink                           items,
	bpa_out_if.source                        results,
	input  wire logic                        cfg_we,
	input  wire logic [bpa_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [bpa_pkg::SizeW-1:0]   cfg_data
);

	localparam int IW = $clog2(MAX_ITEMS);      // store address
	localparam int CW = $clog2(MAX_ITEMS + 1);  // item count, holds MAX_ITEMS

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,  // loading items
		ST_CHK_RD = 8'b0000_0010,  // read size for oversize check
		ST_CHK_EV = 8'b0000_0100,  // compare size with capacity
		ST_PK_RD  = 8'b0000_1000,  // skip assigned item or read its size
		ST_PK_EV  = 8'b0001_0000,  // try to add the item to the open bin
		ST_EM_RD  = 8'b0010_0000,  // read bin of the next result
		ST_EM_OUT = 8'b0100_0000,  // hand result to the output register
		ST_ERR    = 8'b1000_0000   // hand the rejection result over
	} state_t;

	state_t state_q;

	// registers
	logic [bpa_pkg::SizeW-1:0] capacity_q;
	logic                      compact_q;

	// sequencer
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            done_q;
	logic [IW-1:0]            idx_q;
	logic [MAX_ITEMS-1:0]     flags_q;
	logic [bpa_pkg::BinW-1:0] bin_q;
	logic [bpa_pkg::SizeW-1:0] fill_q;

	// memories
	logic [bpa_pkg::SizeW-1:0] size_mem [MAX_ITEMS];
	logic [bpa_pkg::BinW-1:0]  bin_mem  [MAX_ITEMS];
	logic [bpa_pkg::SizeW-1:0] size_rd_q;
	logic [bpa_pkg::BinW-1:0]  bin_rd_q;

	// output register
	logic                      out_valid_q;
	logic [bpa_pkg::SlotW-1:0] out_slot_q;
	logic [bpa_pkg::BinW-1:0]  out_bin_q;
	logic                      out_err_q;
	logic                      out_last_q;

	logic                      load_acc;
	logic                      store_room;
	logic                      out_free;
	logic                      out_load;
	logic [IW-1:0]             last_idx;
	logic                      at_last;
	logic [CW-1:0]             done_inc;
	logic [bpa_pkg::SizeW-1:0] alu_fill;
	bpa_pkg::alu_res_t         alu_res;
	logic                      size_rd_en;
	logic                      bin_wr_en;

	assign items.ready = (state_q == ST_IDLE);
	assign load_acc    = items.valid && items.ready;
	assign store_room  = (count_q < CW'(MAX_ITEMS));
	assign out_free    = !out_valid_q || results.ready;
	assign out_load    = out_free && ((state_q == ST_EM_OUT) || (state_q == ST_ERR));
	assign last_idx    = IW'(count_q - 1'b1);
	assign at_last     = (idx_q == last_idx);
	assign done_inc    = done_q + 1'b1;

	// oversize check compares the size alone, packing adds the open fill
	assign alu_fill = (state_q == ST_CHK_EV) ? '0 : fill_q;

	bpa_alu u_alu (
		.fill     (alu_fill),
		.size     (size_rd_q),
		.capacity (capacity_q),
		.res      (alu_res)
	);

	assign size_rd_en = (state_q == ST_CHK_RD) ||
		((state_q == ST_PK_RD) && !flags_q[idx_q]);
	assign bin_wr_en  = (state_q == ST_PK_EV) && alu_res.fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			compact_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpa_pkg::CFG_BIN_CAPACITY: capacity_q <= cfg_data;
				bpa_pkg::CFG_COMPACT_MODE: compact_q  <= cfg_data[0];
				default: ;  // index beyond the list: ignored
			endcase
		end
	end

	// size store: written while loading, one registered read port
	always_ff @(posedge clk) begin
		if (load_acc && store_room) begin
			size_mem[count_q[IW-1:0]] <= items.item_size;
		end
		if (size_rd_en) begin
			size_rd_q <= size_mem[idx_q];
		end
	end

	// bin store: written on each assignment, read back for the results
	always_ff @(posedge clk) begin
		if (bin_wr_en) begin
			bin_mem[idx_q] <= bin_q;
		end
		if (state_q == ST_EM_RD) begin
			bin_rd_q <= bin_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			done_q      <= '0;
			idx_q       <= '0;
			flags_q     <= '0;
			bin_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
			out_bin_q   <= '0;
			out_err_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						// a full store drops the size but keeps the mark
						if (store_room) begin
							count_q <= count_q + 1'b1;
						end
						if (items.last_item) begin
							idx_q   <= '0;
							state_q <= ST_CHK_RD;
						end
					end
				end
				ST_CHK_RD: begin
					state_q <= ST_CHK_EV;
				end
				ST_CHK_EV: begin
					if (!alu_res.fits) begin
						state_q <= ST_ERR;  // idx_q names the offending item
					end else if (at_last) begin
						idx_q   <= '0;
						flags_q <= '0;
						bin_q   <= '0;
						fill_q  <= '0;
						done_q  <= '0;
						state_q <= ST_PK_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_CHK_RD;
					end
				end
				ST_PK_RD: begin
					if (!flags_q[idx_q]) begin
						state_q <= ST_PK_EV;
					end else if (at_last) begin
						// pass over: open the next bin or finish
						idx_q   <= '0;
						bin_q   <= bin_q + 1'b1;
						fill_q  <= '0;
						state_q <= (done_q == count_q) ? ST_EM_RD : ST_PK_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PK_EV: begin
					if (alu_res.fits) begin
						flags_q[idx_q] <= 1'b1;
						done_q         <= done_inc;
					end
					if (at_last || (!alu_res.fits && !compact_q)) begin
						// end of pass; next-fit closes the bin at a misfit
						idx_q  <= '0;
						bin_q  <= bin_q + 1'b1;
						fill_q <= '0;
						if ((alu_res.fits ? done_inc : done_q) == count_q) begin
							state_q <= ST_EM_RD;
						end else begin
							state_q <= ST_PK_RD;
						end
					end else begin
						if (alu_res.fits) begin
							fill_q <= alu_res.sum;
						end
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_PK_RD;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_OUT;
				end
				ST_EM_OUT: begin
					if (out_free) begin
						out_slot_q  <= bpa_pkg::SlotW'(idx_q);
						out_bin_q   <= bin_rd_q;
						out_err_q   <= 1'b0;
						out_last_q  <= at_last;
						if (at_last) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_EM_RD;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_slot_q  <= bpa_pkg::SlotW'(idx_q);
						out_bin_q   <= '0;
						out_err_q   <= 1'b1;
						out_last_q  <= 1'b1;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid       = out_valid_q;
	assign results.item_slot   = out_slot_q;
	assign results.bin_index   = out_bin_q;
	assign results.too_large   = out_err_q;
	assign results.last_result = out_last_q;

endmodule

`default_nettype wire
